@@ rtl/core/tpd_pkg.sv @@
// Shared constants, types and helpers of the two-phase task dispatcher.
`default_nettype none
package tpd_pkg;
	localparam int MAX_WORKERS = 64;
	localparam int MAX_TASKS   = 256;

	localparam int WKR_AW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int TASK_AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int WCNT_W  = $clog2(MAX_WORKERS + 1);
	localparam int TCNT_W  = $clog2(MAX_TASKS + 1);
	localparam int SCAN_W  = (WCNT_W > TCNT_W) ? WCNT_W : TCNT_W;

	localparam int CFG_W  = 9;
	localparam int PORT_W = 16;
	localparam int TIDX_W = 8;

	typedef enum logic [1:0] {OP_ONLINE, OP_STARTING, OP_DONE, OP_OTHER} op_t;
	typedef enum logic [1:0] {ORD_MAP, ORD_REDUCE, ORD_CLEAN, ORD_PING} order_t;
	typedef enum logic [1:0] {PH_MAP, PH_REDUCE, PH_CLEAN} phase_t;
	typedef enum logic [1:0] {WS_IDLE, WS_WAITING, WS_BUSY} wstat_t;
	typedef enum logic [1:0] {TS_UNASSIGNED, TS_IN_PROG, TS_DONE} tstate_t;
	typedef enum logic [1:0] {CL_NONE, CL_SENT, CL_FINISHED} clean_t;
	typedef enum logic {CFG_NUM_MAP, CFG_NUM_REDUCE} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_REG, S_WSCAN, S_TSCAN, S_WFIND, S_CLEAN, S_CLEAN_WR, S_FIN
	} state_t;

	typedef struct packed {
		logic [PORT_W-1:0]  port;
		wstat_t             status;
		logic               has_task;
		logic [TASK_AW-1:0] task_idx;
	} wkr_entry_t;

	localparam int WKR_W = $bits(wkr_entry_t);

	typedef struct packed {
		logic              we;
		logic [WKR_AW-1:0] addr;
		wkr_entry_t        data;
	} wkr_wr_t;

	typedef struct packed {
		logic               we;
		logic               reduce;
		logic [TASK_AW-1:0] addr;
		tstate_t            data;
	} tsk_wr_t;

	typedef struct packed {
		logic              idle;
		logic [WCNT_W-1:0] count;
		phase_t            phase;
	} seq_sts_t;

	// Task count registers above the table size act as the table size
	function automatic logic [TCNT_W-1:0] clamp_tasks(input logic [CFG_W-1:0] n);
		logic [TCNT_W-1:0] r;
		if (int'(n) > MAX_TASKS) r = TCNT_W'(MAX_TASKS);
		else r = TCNT_W'(n);
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/tpd_evt_if.sv @@
// Worker event channel.
`default_nettype none
interface tpd_evt_if;
	import tpd_pkg::*;
	logic              valid;
	logic              ready;
	op_t               operation;
	logic [PORT_W-1:0] worker_port;

	modport source (output valid, operation, worker_port, input ready);
	modport sink (input valid, operation, worker_port, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tpd_ord_if.sv @@
// Order channel toward the workers.
`default_nettype none
interface tpd_ord_if;
	import tpd_pkg::*;
	logic              valid;
	logic              ready;
	order_t            order_kind;
	logic [PORT_W-1:0] dest_port;
	logic [TIDX_W-1:0] task_index;
	phase_t            phase_now;

	modport source (output valid, order_kind, dest_port, task_index, phase_now, input ready);
	modport sink (input valid, order_kind, dest_port, task_index, phase_now, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tpd_ram.sv @@
// Generic RAM: one write port, one read port, registered read data.
`default_nettype none
module tpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/tpd_task_table.sv @@
// Task state table: RAM plus per-entry valid bits so reset reads as unassigned.
`default_nettype none
module tpd_task_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [tpd_pkg::TASK_AW-1:0] waddr,
	input  tpd_pkg::tstate_t          wdata,
	input  logic                      re,
	input  logic [tpd_pkg::TASK_AW-1:0] raddr,
	output tpd_pkg::tstate_t          rdata
);
	import tpd_pkg::*;

	logic [MAX_TASKS-1:0] vld_q;
	logic                 rd_vld_q;
	logic [1:0]           ram_rdata;

	tpd_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			if (re) rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? tstate_t'(ram_rdata) : TS_UNASSIGNED;
endmodule
`default_nettype wire

@@ rtl/core/tpd_seq.sv @@
// Event sequencer: table scans, dispatch, phase control and order register.
`default_nettype none
module tpd_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	tpd_evt_if.sink                     evt,
	tpd_ord_if.source                   ord,
	input  logic [tpd_pkg::TCNT_W-1:0]  n_map,
	input  logic [tpd_pkg::TCNT_W-1:0]  n_reduce,
	output tpd_pkg::wkr_wr_t            wkr_wr,
	output logic                        wkr_re,
	output logic [tpd_pkg::WKR_AW-1:0]  wkr_raddr,
	input  tpd_pkg::wkr_entry_t         wkr_rdata,
	output tpd_pkg::tsk_wr_t            tsk_wr,
	output logic                        tsk_re,
	output logic [tpd_pkg::TASK_AW-1:0] tsk_raddr,
	input  tpd_pkg::tstate_t            map_rdata,
	input  tpd_pkg::tstate_t            reduce_rdata,
	output tpd_pkg::seq_sts_t           sts
);
	import tpd_pkg::*;

	state_t              state_q, state_d;
	op_t                 op_q;
	logic [PORT_W-1:0]   port_q;
	logic [WCNT_W-1:0]   count_q;
	phase_t              phase_q;
	clean_t              clean_q;
	logic [SCAN_W-1:0]   idx_q;
	logic                rd_vld_s1;
	logic [SCAN_W-1:0]   rd_idx_s1;
	logic                busy_q;
	logic [TASK_AW-1:0]  target_q;
	logic                res_q;
	order_t              res_kind_q;
	logic [PORT_W-1:0]   res_port_q;
	logic [TASK_AW-1:0]  res_task_q;
	logic                ovalid_q;
	order_t              okind_q;
	logic [PORT_W-1:0]   oport_q;
	logic [TIDX_W-1:0]   otask_q;
	phase_t              ophase_q;

	logic [SCAN_W-1:0]   limit;
	logic                issue;
	logic                scan_end;
	logic                w_match;
	logic                w_idle;
	tstate_t             t_st;
	logic                t_free;
	logic                t_busy;
	logic                load;

	// Scan bound per state; the scan issues one read a cycle and checks each read in the cycle after
	always_comb begin
		unique case (state_q)
			S_TSCAN: begin
				if (phase_q == PH_REDUCE) limit = SCAN_W'(n_reduce);
				else if (phase_q == PH_MAP) limit = SCAN_W'(n_map);
				else limit = '0;
			end
			S_WSCAN, S_WFIND: limit = SCAN_W'(count_q);
			default: limit = '0;
		endcase
	end

	assign issue    = idx_q < limit;
	assign scan_end = !rd_vld_s1 && !issue;
	assign w_match  = rd_vld_s1 && (wkr_rdata.port == port_q);
	assign w_idle   = rd_vld_s1 && (wkr_rdata.status == WS_IDLE);
	assign t_st     = (phase_q == PH_REDUCE) ? reduce_rdata : map_rdata;
	assign t_free   = rd_vld_s1 && (t_st == TS_UNASSIGNED);
	assign t_busy   = rd_vld_s1 && (t_st == TS_IN_PROG);
	assign load     = (state_q == S_FIN) && res_q && (!ovalid_q || ord.ready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (evt.valid) begin
					unique case (evt.operation)
						OP_ONLINE: state_d = S_REG;
						OP_STARTING, OP_DONE: state_d = S_WSCAN;
						OP_OTHER: state_d = S_TSCAN;
					endcase
				end
			end
			S_REG: state_d = S_TSCAN;
			S_WSCAN: begin
				if ((op_q == OP_DONE && w_match) || scan_end) state_d = S_TSCAN;
			end
			S_TSCAN: begin
				if (phase_q == PH_CLEAN) state_d = S_CLEAN;
				else if (t_free) state_d = S_WFIND;
				else if (scan_end) state_d = S_CLEAN;
			end
			S_WFIND: begin
				if (w_idle || scan_end) state_d = S_CLEAN;
			end
			S_CLEAN: begin
				if (phase_q == PH_CLEAN && clean_q == CL_NONE) state_d = S_CLEAN_WR;
				else state_d = S_FIN;
			end
			S_CLEAN_WR: state_d = S_FIN;
			S_FIN: begin
				if (!res_q || !ovalid_q || ord.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Table requests
	always_comb begin
		evt.ready = (state_q == S_IDLE);
		wkr_re    = 1'b0;
		wkr_raddr = idx_q[WKR_AW-1:0];
		wkr_wr    = '0;
		tsk_re    = 1'b0;
		tsk_raddr = idx_q[TASK_AW-1:0];
		tsk_wr    = '0;
		unique case (state_q)
			S_REG: begin
				wkr_wr.we   = int'(count_q) < MAX_WORKERS;
				wkr_wr.addr = count_q[WKR_AW-1:0];
				wkr_wr.data.port     = port_q;
				wkr_wr.data.status   = WS_IDLE;
				wkr_wr.data.has_task = 1'b0;
			end
			S_WSCAN: begin
				wkr_re      = issue;
				wkr_wr.we   = w_match;
				wkr_wr.addr = rd_idx_s1[WKR_AW-1:0];
				if (op_q == OP_DONE) begin
					wkr_wr.data.port     = wkr_rdata.port;
					wkr_wr.data.status   = WS_IDLE;
					wkr_wr.data.has_task = 1'b0;
					// done event: the worker's task is finished, if it had one and the phase is not clean
					tsk_wr.we     = w_match && wkr_rdata.has_task && phase_q != PH_CLEAN;
					tsk_wr.reduce = (phase_q == PH_REDUCE);
					tsk_wr.addr   = wkr_rdata.task_idx;
					tsk_wr.data   = TS_DONE;
				end else begin
					wkr_wr.data        = wkr_rdata;
					wkr_wr.data.status = WS_BUSY;
				end
			end
			S_TSCAN: tsk_re = issue;
			S_WFIND: begin
				wkr_re      = issue;
				wkr_wr.we   = w_idle;
				wkr_wr.addr = rd_idx_s1[WKR_AW-1:0];
				wkr_wr.data.port     = wkr_rdata.port;
				wkr_wr.data.status   = WS_WAITING;
				wkr_wr.data.has_task = 1'b1;
				wkr_wr.data.task_idx = target_q;
				tsk_wr.we     = w_idle;
				tsk_wr.reduce = (phase_q == PH_REDUCE);
				tsk_wr.addr   = target_q;
				tsk_wr.data   = TS_IN_PROG;
			end
			S_CLEAN: begin
				wkr_re    = 1'b1;
				wkr_raddr = '0;
			end
			S_CLEAN_WR: begin
				wkr_wr.we          = 1'b1;
				wkr_wr.addr        = '0;
				wkr_wr.data        = wkr_rdata;
				wkr_wr.data.status = WS_WAITING;
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			phase_q   <= PH_MAP;
			clean_q   <= CL_NONE;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			busy_q    <= 1'b0;
			res_q     <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) idx_q <= idx_q + SCAN_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (evt.valid) begin
						res_q  <= 1'b0;
						busy_q <= 1'b0;
					end
				end
				S_REG: begin
					if (int'(count_q) < MAX_WORKERS) count_q <= count_q + WCNT_W'(1);
				end
				S_WSCAN: begin
					if (op_q == OP_DONE && w_match && phase_q == PH_CLEAN)
						clean_q <= CL_FINISHED;
				end
				S_TSCAN: begin
					if (phase_q != PH_CLEAN) begin
						if (t_busy) busy_q <= 1'b1;
						// nothing pending or in progress: phase is over
						if (!t_free && scan_end && !busy_q) begin
							if (phase_q == PH_MAP) begin
								phase_q <= PH_REDUCE;
								res_q   <= 1'b1;
							end else begin
								phase_q <= PH_CLEAN;
							end
						end
					end
				end
				S_WFIND: if (w_idle) res_q <= 1'b1;
				S_CLEAN_WR: begin
					clean_q <= CL_SENT;
					res_q   <= 1'b1;
				end
				default: ;
			endcase

			if (load) ovalid_q <= 1'b1;
			else if (ord.ready) ovalid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && evt.valid) begin
			op_q   <= evt.operation;
			port_q <= evt.worker_port;
		end
		rd_idx_s1 <= idx_q;
		if (state_q == S_TSCAN && t_free) target_q <= rd_idx_s1[TASK_AW-1:0];
		if (state_q == S_TSCAN && phase_q == PH_MAP) begin
			res_kind_q <= ORD_PING;
			res_port_q <= port_q;
			res_task_q <= '0;
		end
		if (state_q == S_WFIND && w_idle) begin
			res_kind_q <= (phase_q == PH_REDUCE) ? ORD_REDUCE : ORD_MAP;
			res_port_q <= wkr_rdata.port;
			res_task_q <= target_q;
		end
		if (state_q == S_CLEAN_WR) begin
			res_kind_q <= ORD_CLEAN;
			res_port_q <= wkr_rdata.port;
			res_task_q <= '0;
		end
		if (load) begin
			okind_q  <= res_kind_q;
			oport_q  <= res_port_q;
			otask_q  <= TIDX_W'(res_task_q);
			ophase_q <= phase_q;
		end
	end

	assign ord.valid      = ovalid_q;
	assign ord.order_kind = okind_q;
	assign ord.dest_port  = oport_q;
	assign ord.task_index = otask_q;
	assign ord.phase_now  = ophase_q;

	assign sts.idle  = (state_q == S_IDLE);
	assign sts.count = count_q;
	assign sts.phase = phase_q;
endmodule
`default_nettype wire

@@ rtl/core/two_phase_task_dispatcher_core.sv @@
// Top level of the two-phase task dispatcher.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+---------------------------------------------
//  evt     | in  | valid / ready  | operation, worker_port
//  ord     | out | valid / ready  | order_kind, dest_port, task_index, phase_now
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
// The worker and task tables are single-read-port RAMs, scanned one entry per cycle.
// Reset clears counters, phase and task valid bits at once; no clearing pass.
// evt.ready is high only between events; a finished order waits in the output
// register while the next event is accepted, and the block stalls before
// loading a second one.
`default_nettype none
module two_phase_task_dispatcher_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  tpd_pkg::cfg_reg_t         cfg_index,
	input  logic [tpd_pkg::CFG_W-1:0] cfg_data,
	tpd_evt_if.sink                   evt,
	tpd_ord_if.source                 ord
);
	import tpd_pkg::*;

	logic [CFG_W-1:0]   num_map_q;
	logic [CFG_W-1:0]   num_reduce_q;
	logic [TCNT_W-1:0]  n_map;
	logic [TCNT_W-1:0]  n_reduce;
	wkr_wr_t            wkr_wr;
	logic               wkr_re;
	logic [WKR_AW-1:0]  wkr_raddr;
	logic [WKR_W-1:0]   wkr_rdata_raw;
	wkr_entry_t         wkr_rdata;
	tsk_wr_t            tsk_wr;
	logic               tsk_re;
	logic [TASK_AW-1:0] tsk_raddr;
	tstate_t            map_rdata;
	tstate_t            reduce_rdata;
	seq_sts_t           sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_map_q    <= '0;
			num_reduce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_MAP: num_map_q <= cfg_data;
				CFG_NUM_REDUCE: num_reduce_q <= cfg_data;
			endcase
		end
	end

	assign n_map    = clamp_tasks(num_map_q);
	assign n_reduce = clamp_tasks(num_reduce_q);

	tpd_ram #(.WIDTH(WKR_W), .DEPTH(MAX_WORKERS)) u_wkr_ram (
		.clk   (clk),
		.we    (wkr_wr.we),
		.waddr (wkr_wr.addr),
		.wdata (wkr_wr.data),
		.re    (wkr_re),
		.raddr (wkr_raddr),
		.rdata (wkr_rdata_raw)
	);

	assign wkr_rdata = wkr_entry_t'(wkr_rdata_raw);

	tpd_task_table u_map_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tsk_wr.we && !tsk_wr.reduce),
		.waddr  (tsk_wr.addr),
		.wdata  (tsk_wr.data),
		.re     (tsk_re),
		.raddr  (tsk_raddr),
		.rdata  (map_rdata)
	);

	tpd_task_table u_reduce_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tsk_wr.we && tsk_wr.reduce),
		.waddr  (tsk_wr.addr),
		.wdata  (tsk_wr.data),
		.re     (tsk_re),
		.raddr  (tsk_raddr),
		.rdata  (reduce_rdata)
	);

	tpd_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt          (evt),
		.ord          (ord),
		.n_map        (n_map),
		.n_reduce     (n_reduce),
		.wkr_wr       (wkr_wr),
		.wkr_re       (wkr_re),
		.wkr_raddr    (wkr_raddr),
		.wkr_rdata    (wkr_rdata),
		.tsk_wr       (tsk_wr),
		.tsk_re       (tsk_re),
		.tsk_raddr    (tsk_raddr),
		.map_rdata    (map_rdata),
		.reduce_rdata (reduce_rdata),
		.sts          (sts)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sts.count) <= MAX_WORKERS)
		else $error("worker count above table size");

	a_phase_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.phase != PH_MAP) |=> (sts.phase != PH_MAP))
		else $error("phase went back to map");

	a_order_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ord.valid) |-> !$past(evt.ready))
		else $error("order loaded while sequencer was idle");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.idle && !evt.valid) |=> $stable(sts.count))
		else $error("worker count changed without an event");
endmodule
`default_nettype wire
